// ===== sv/kmp_pkg.sv =====
// Shared types and constants of the streaming KMP matcher.
// No dependencies; imported by every module of the block.
package kmp_pkg;

  // Command carried in the low tuser bit of an input word
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEXT = 1'b1;

  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_FALLBACK
  } kmp_state_e;

  // Control from the sequencer to the position counters
  typedef struct packed {
    logic clear;
    logic advance;
    logic newline;
  } kmp_pos_ctl_t;

endpackage

// ===== sv/kmp_store.sv =====
// Pattern byte memory and failure-table memory of the KMP matcher.
// Two single-port-write, registered-read arrays; depends on kmp_pkg.
module kmp_store
  import kmp_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk_i,
  input  logic          pat_we_i,
  input  logic [AW-1:0] pat_waddr_i,
  input  logic [7:0]    pat_wdata_i,
  input  logic [AW-1:0] pat_raddr_i,
  output logic [7:0]    pat_rdata_o,
  input  logic          fail_we_i,
  input  logic [AW-1:0] fail_waddr_i,
  input  logic [AW-1:0] fail_wdata_i,
  input  logic [AW-1:0] fail_raddr_i,
  output logic [AW-1:0] fail_rdata_o
);

  logic [7:0]    pat_mem  [DEPTH];
  logic [AW-1:0] fail_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (pat_we_i) begin
      pat_mem[pat_waddr_i] <= pat_wdata_i;
    end
    pat_rdata_o <= pat_mem[pat_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (fail_we_i) begin
      fail_mem[fail_waddr_i] <= fail_wdata_i;
    end
    fail_rdata_o <= fail_mem[fail_raddr_i];
  end

endmodule

// ===== sv/kmp_pos.sv =====
// Text position counters of the KMP matcher: byte index, newline count and
// the raw and newline-stripped match offsets. Depends on kmp_pkg.
module kmp_pos
  import kmp_pkg::*;
#(
  parameter int POS_WIDTH = 32,
  parameter int LW        = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  kmp_pos_ctl_t  ctl_i,
  input  logic [LW-1:0] pat_len_i,
  output logic [31:0]   stripped_o,
  output logic [31:0]   raw_o
);

  logic [POS_WIDTH-1:0] idx_q, idx_d;
  logic [POS_WIDTH-1:0] nl_q, nl_d;
  logic [POS_WIDTH-1:0] raw_q, raw_d;
  logic [POS_WIDTH-1:0] idx_base, nl_base, stripped;
  logic [POS_WIDTH:0]   here_inc, len_ext;

  always_comb begin
    idx_base = ctl_i.clear ? '0 : idx_q;
    nl_base  = ctl_i.clear ? '0 : nl_q;
    idx_d    = idx_base;
    nl_d     = nl_base;
    raw_d    = raw_q;
    // Offset of the byte after this one, one bit wider so it cannot wrap
    here_inc = {1'b0, idx_base} + (POS_WIDTH+1)'(1);
    len_ext  = (POS_WIDTH+1)'(pat_len_i);
    if (ctl_i.advance) begin
      idx_d = (&idx_base) ? idx_base : idx_base + POS_WIDTH'(1);
      if (ctl_i.newline) begin
        nl_d = (&nl_base) ? nl_base : nl_base + POS_WIDTH'(1);
      end
      // Start offset if this byte completes a match; floor at zero
      raw_d = (here_inc > len_ext) ? POS_WIDTH'(here_inc - len_ext) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      nl_q  <= '0;
    end else begin
      idx_q <= idx_d;
      nl_q  <= nl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q <= raw_d;
  end

  assign stripped   = (raw_q > nl_q) ? raw_q - nl_q : '0;
  assign stripped_o = 32'(stripped);
  assign raw_o      = 32'(raw_q);

endmodule

// ===== sv/kmp_stream_matcher_unit.sv =====
// Streaming KMP matcher: pattern bytes build the failure table as they load,
// text bytes walk the automaton held in two registered-read memories.
// A word that walks the table is checked in ST_STEP, taking one failure-table step per mismatch;
// a first pattern byte or a dropped word stays in ST_IDLE; a text match waits in ST_FALLBACK for the output.
// Input is accepted only in ST_IDLE, so each word is finished before the next is taken.
// Reset: asynchronous, clears lengths, counters and state; memories need none.
module kmp_stream_matcher_unit
  import kmp_pkg::*;
#(
  parameter int MAX_PATTERN = 64,
  parameter int POS_WIDTH   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,  // [0] cmd, [1] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // [31:0] stripped_position, [63:32] raw_position
);

  localparam int AW = $clog2(MAX_PATTERN);
  localparam int LW = $clog2(MAX_PATTERN + 1);

  kmp_state_e    state_q, state_d;
  logic [LW-1:0] pl_q, pl_d;
  logic [AW-1:0] bp_q, bp_d;
  logic [AW-1:0] ml_q, ml_d;
  logic [AW-1:0] j_q, j_d;
  logic [AW-1:0] k_q, k_d;
  logic          cmd_q, cmd_d;
  logic [7:0]    byte_q, byte_d;
  logic          out_valid_q, out_valid_d;
  logic [31:0]   out_strip_q, out_strip_d;
  logic [31:0]   out_raw_q, out_raw_d;

  logic          accept, in_cmd, in_restart, load_full, out_free;
  logic [7:0]    in_byte;
  logic [LW-1:0] k_eff, pl_m1, j_fin;
  logic [AW-1:0] j_start, f_next;
  logic          p_match, mismatch;

  logic          pat_we, fail_we;
  logic [AW-1:0] pat_waddr, pat_raddr, fail_waddr, fail_wdata, fail_raddr;
  logic [7:0]    pat_rdata;
  logic [AW-1:0] fail_rdata;

  kmp_pos_ctl_t  pos_ctl;
  logic [31:0]   pos_stripped, pos_raw;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_cmd        = s_axis_tuser[0];
  assign in_restart    = s_axis_tuser[1];
  assign in_byte       = s_axis_tdata;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign k_eff     = in_restart ? '0 : pl_q;
  assign load_full = (k_eff == LW'(MAX_PATTERN));
  assign j_start   = (in_restart || (LW'(ml_q) >= pl_q)) ? '0 : ml_q;
  assign pl_m1     = pl_q - LW'(1);

  assign p_match  = (pat_rdata == byte_q);
  assign mismatch = (j_q != '0) && !p_match;
  assign f_next   = (LW'(fail_rdata) < LW'(j_q)) ? fail_rdata : '0;
  assign j_fin    = LW'(j_q) + LW'(p_match);

  kmp_store #(
    .DEPTH(MAX_PATTERN),
    .AW   (AW)
  ) u_store (
    .clk_i       (clk_i),
    .pat_we_i    (pat_we),
    .pat_waddr_i (pat_waddr),
    .pat_wdata_i (in_byte),
    .pat_raddr_i (pat_raddr),
    .pat_rdata_o (pat_rdata),
    .fail_we_i   (fail_we),
    .fail_waddr_i(fail_waddr),
    .fail_wdata_i(fail_wdata),
    .fail_raddr_i(fail_raddr),
    .fail_rdata_o(fail_rdata)
  );

  kmp_pos #(
    .POS_WIDTH(POS_WIDTH),
    .LW       (LW)
  ) u_pos (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (pos_ctl),
    .pat_len_i (pl_q),
    .stripped_o(pos_stripped),
    .raw_o     (pos_raw)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_LOAD) begin
            if (!load_full && (k_eff != '0)) begin
              state_d = ST_STEP;
            end
          end else if (pl_q != '0) begin
            state_d = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        if (!mismatch) begin
          if ((cmd_q == CMD_TEXT) && (j_fin == pl_q)) begin
            state_d = ST_FALLBACK;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FALLBACK: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    pl_d        = pl_q;
    bp_d        = bp_q;
    ml_d        = ml_q;
    j_d         = j_q;
    k_d         = k_q;
    cmd_d       = cmd_q;
    byte_d      = byte_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_strip_d = out_strip_q;
    out_raw_d   = out_raw_q;
    pat_we      = 1'b0;
    pat_waddr   = k_eff[AW-1:0];
    pat_raddr   = j_q;
    fail_we     = 1'b0;
    fail_waddr  = k_q;
    fail_wdata  = j_fin[AW-1:0];
    fail_raddr  = j_q - AW'(1);
    pos_ctl     = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d  = in_cmd;
          byte_d = in_byte;
          if (in_cmd == CMD_LOAD) begin
            if (in_restart) begin
              pl_d          = '0;
              bp_d          = '0;
              ml_d          = '0;
              pos_ctl.clear = 1'b1;
            end
            if (!load_full) begin
              pat_we = 1'b1;
              k_d    = k_eff[AW-1:0];
              if (k_eff == '0) begin
                // First byte: its failure value is zero by definition
                fail_we    = 1'b1;
                fail_waddr = '0;
                fail_wdata = '0;
                pl_d       = LW'(1);
                bp_d       = '0;
              end else begin
                j_d        = bp_q;
                pat_raddr  = bp_q;
                fail_raddr = bp_q - AW'(1);
              end
            end
          end else begin
            if (in_restart) begin
              ml_d          = '0;
              pos_ctl.clear = 1'b1;
            end
            if (pl_q != '0) begin
              pos_ctl.advance = 1'b1;
              pos_ctl.newline = (in_byte == NEWLINE_CHAR);
              j_d             = j_start;
              pat_raddr       = j_start;
              fail_raddr      = j_start - AW'(1);
            end
          end
        end
      end
      ST_STEP: begin
        if (mismatch) begin
          // Fall back one failure-table step and reread at the new prefix
          j_d        = f_next;
          pat_raddr  = f_next;
          fail_raddr = f_next - AW'(1);
        end else if (cmd_q == CMD_LOAD) begin
          fail_we = 1'b1;
          bp_d    = j_fin[AW-1:0];
          pl_d    = LW'(k_q) + LW'(1);
        end else if (j_fin == pl_q) begin
          fail_raddr = pl_m1[AW-1:0];
        end else begin
          ml_d = j_fin[AW-1:0];
        end
      end
      ST_FALLBACK: begin
        // Hold the read address so the data survives an output stall
        fail_raddr = pl_m1[AW-1:0];
        if (out_free) begin
          out_valid_d = 1'b1;
          out_strip_d = pos_stripped;
          out_raw_d   = pos_raw;
          ml_d        = (LW'(fail_rdata) < pl_q) ? fail_rdata : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pl_q        <= '0;
      bp_q        <= '0;
      ml_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pl_q        <= pl_d;
      bp_q        <= bp_d;
      ml_q        <= ml_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q         <= j_d;
    k_q         <= k_d;
    cmd_q       <= cmd_d;
    byte_q      <= byte_d;
    out_strip_q <= out_strip_d;
    out_raw_q   <= out_raw_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_raw_q, out_strip_q};

  a_match_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ml_q == '0) || (LW'(ml_q) < pl_q))
    else $error("matched length not below pattern length");

  a_walk_has_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (pl_q != '0))
    else $error("table walk without a loaded pattern");

  a_fallback_is_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FALLBACK) |-> (cmd_q == CMD_TEXT))
    else $error("match fallback entered on a pattern load");

  a_result_from_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FALLBACK))
    else $error("result word not produced by a completed match");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_cmd == CMD_LOAD) && !in_restart && (pl_q == LW'(MAX_PATTERN)))
      |=> (pl_q == LW'(MAX_PATTERN)) && (state_q == ST_IDLE))
    else $error("pattern byte beyond capacity not dropped");

endmodule
